### hw/rtl/bgcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_pkg
// Shared widths, register indexes and types for the gait contact scheduler.
// ----------------------------------------------------------------------------
package bgcs_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SW   = 5;    // segment count width
  localparam int IW   = 10;   // iterations per segment width
  localparam int OW   = 4;    // offset width
  localparam int UW   = 14;   // cycle length in iterations, up to 16 * 1023
  localparam int CW   = 32;   // iteration count width
  localparam int QW   = 16;   // fraction width
  localparam int SUBW = 17;   // Q1.16 subphase width
  localparam int TW   = 32;   // contact table width
  localparam int AW   = 5;    // APB address width

  localparam int NLANE         = 5;  // phase, two stance, two swing
  localparam int MOD_STEPS     = 32; // shifted-divisor steps for count mod cycle
  localparam int MOD_PER_STAGE = 4;
  localparam int MOD_STAGES    = MOD_STEPS / MOD_PER_STAGE;
  localparam int DIV_STAGES    = 4;
  localparam int DIV_PER_STAGE = QW / DIV_STAGES;
  // input capture, modulo stages, then prep and the first three divide stages
  localparam int NSTG          = 1 + MOD_STAGES + DIV_STAGES;

  typedef enum logic [2:0] {
    REG_HORIZON_SEGMENTS = 3'd0,
    REG_ITERATIONS       = 3'd1,
    REG_OFFSET_LEFT      = 3'd2,
    REG_OFFSET_RIGHT     = 3'd3,
    REG_DURATION_LEFT    = 3'd4,
    REG_DURATION_RIGHT   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    LANE_DIV  = 2'd0,
    LANE_ZERO = 2'd1,
    LANE_FULL = 2'd2
  } lane_mode_t;

  typedef struct packed {
    lane_mode_t      mode;
    logic [UW-1:0]   rem;
    logic [QW-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic [3:0]              seg;
    logic [TW-1:0]           contact_bits;
    lane_t [NLANE-1:0]       lane;
  } stg_t;

  // effective configuration, first level
  typedef struct packed {
    logic [SW-1:0]          s;
    logic [IW-1:0]          it;
    logic [UW-1:0]          u;
    logic [1:0][OW-1:0]     off;
    logic [1:0][SW-1:0]     dur;
  } cfg_a_t;

  // window bounds, second level
  typedef struct packed {
    logic [1:0][UW-1:0] cstart;
    logic [1:0][UW-1:0] clen;
    logic [1:0][UW-1:0] sstart;
    logic [1:0][UW-1:0] slen;
  } cfg_b_t;

  typedef struct packed {
    logic [3:0]      segment_index;
    logic [QW-1:0]   cycle_phase;
    logic [SUBW-1:0] contact_sub_left;
    logic [SUBW-1:0] contact_sub_right;
    logic [SUBW-1:0] swing_sub_left;
    logic [SUBW-1:0] swing_sub_right;
    logic [TW-1:0]   contact_table;
  } out_t;

endpackage

### hw/rtl/bgcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_if
// Valid/ready channels for iteration counts and scheduler results.
// ----------------------------------------------------------------------------
interface bgcs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] current_iteration;

  modport source (output valid, output current_iteration, input ready);
  modport sink   (input valid, input current_iteration, output ready);
endinterface

interface bgcs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  segment_index;
  logic [15:0] cycle_phase;
  logic [16:0] contact_sub_left;
  logic [16:0] contact_sub_right;
  logic [16:0] swing_sub_left;
  logic [16:0] swing_sub_right;
  logic [31:0] contact_table;

  modport source (output valid, output segment_index, output cycle_phase,
                  output contact_sub_left, output contact_sub_right,
                  output swing_sub_left, output swing_sub_right,
                  output contact_table, input ready);
  modport sink   (input valid, input segment_index, input cycle_phase,
                  input contact_sub_left, input contact_sub_right,
                  input swing_sub_left, input swing_sub_right,
                  input contact_table, output ready);
endinterface

### hw/rtl/biped_gait_contact_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biped_gait_contact_scheduler
// Gait segment, cycle phase, per-leg stance/swing subphases and contact table
// from a controller iteration count.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  in_if     | in        | valid/ready         | current_iteration
//  out_if    | out       | valid/ready         | segment, phase, subphases, table
//  APB       | in        | psel/penable/pready | six config registers
//
//  One transfer per cycle is accepted while the pipe moves. A count passes
//  through the input capture, the 32-step
//  count-modulo-cycle divider (eight stages), one prep stage and the 16-bit
//  fraction dividers (four stages, the last one feeding the output register).
//  The whole pipe holds when the output register is full and not taken.
//  rst_n is synchronous; it clears the valid bits and loads the config registers with their defaults.
// ----------------------------------------------------------------------------
module biped_gait_contact_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  bgcs_in_if.sink           in_if,
  bgcs_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bgcs_pkg::*;

  // config registers
  logic [SW-1:0] seg_cfg_r;
  logic [IW-1:0] it_cfg_r;
  logic [OW-1:0] offl_r, offr_r;
  logic [SW-1:0] durl_r, durr_r;

  cfg_a_t cfga_r, cfga_nxt;
  cfg_b_t cfgb_r, cfgb_nxt;

  logic            en;
  logic [NSTG-1:0] v_r;
  logic [CW-1:0]   mod_rem_r   [0:MOD_STAGES];
  logic [CW-1:0]   mod_rem_nxt [1:MOD_STAGES];
  stg_t            stg_r   [0:DIV_STAGES-1];
  stg_t            stg_nxt [0:DIV_STAGES-1];
  out_t            out_r, out_nxt;
  logic            out_valid_r;
  reg_idx_t        widx;

  // scratch
  logic [CW+UW-1:0]  mt;
  logic [CW-1:0]     mr;
  logic [UW-1:0]     p;
  logic [UW:0]       sr, st;
  logic [3:0]        seg;
  logic [UW-1:0]     ln_start [1:NLANE-1];
  logic [UW-1:0]     ln_len   [0:NLANE-1];
  logic [UW-1:0]     pg;
  logic [5:0]        tstep, tprog;
  logic [TW-1:0]     tbits;
  logic [SW-1:0]     s_w;
  logic [OW:0]       om;
  logic [SW+3:0]     osh;
  logic [1:0][OW-1:0] off_w;
  logic [1:0][SW-1:0] dur_w;
  logic [UW:0]       sst;
  stg_t              prep_s;
  stg_t              last;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cfg_r <= SW'(10);
      it_cfg_r  <= IW'(40);
      offl_r    <= '0;
      offr_r    <= OW'(5);
      durl_r    <= SW'(5);
      durr_r    <= SW'(5);
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_HORIZON_SEGMENTS: seg_cfg_r <= pwdata[SW-1:0];
        REG_ITERATIONS:       it_cfg_r  <= pwdata[IW-1:0];
        REG_OFFSET_LEFT:      offl_r    <= pwdata[OW-1:0];
        REG_OFFSET_RIGHT:     offr_r    <= pwdata[OW-1:0];
        REG_DURATION_LEFT:    durl_r    <= pwdata[SW-1:0];
        REG_DURATION_RIGHT:   durr_r    <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // config read
  always_comb begin
    case (widx)
      REG_HORIZON_SEGMENTS: prdata = 32'(seg_cfg_r);
      REG_ITERATIONS:       prdata = 32'(it_cfg_r);
      REG_OFFSET_LEFT:      prdata = 32'(offl_r);
      REG_OFFSET_RIGHT:     prdata = 32'(offr_r);
      REG_DURATION_LEFT:    prdata = 32'(durl_r);
      REG_DURATION_RIGHT:   prdata = 32'(durr_r);
      default:              prdata = '0;
    endcase
  end

  // clamp segments and iterations, reduce offsets, saturate durations
  always_comb begin
    if (seg_cfg_r == '0)                      s_w = SW'(1);
    else if (seg_cfg_r > SW'(MAX_SEGMENTS))   s_w = SW'(MAX_SEGMENTS);
    else                                      s_w = seg_cfg_r;
    cfga_nxt.s   = s_w;
    cfga_nxt.it  = (it_cfg_r == '0) ? IW'(1) : it_cfg_r;
    cfga_nxt.u   = UW'(cfga_nxt.it * s_w);
    for (int l = 0; l < 2; l++) begin
      om = (l == 0) ? {1'b0, offl_r} : {1'b0, offr_r};
      for (int j = 3; j >= 0; j--) begin
        osh = (SW+4)'(s_w) << j;
        if ((SW+4)'(om) >= osh) om = om - (OW+1)'(osh);
      end
      off_w[l] = om[OW-1:0];
      dur_w[l] = (l == 0) ? durl_r : durr_r;
      if (dur_w[l] > s_w) dur_w[l] = s_w;
    end
    cfga_nxt.off = off_w;
    cfga_nxt.dur = dur_w;
  end

  // window bounds from the effective configuration
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cfgb_nxt.cstart[l] = UW'(cfga_r.off[l] * cfga_r.it);
      cfgb_nxt.clen[l]   = UW'(cfga_r.dur[l] * cfga_r.it);
      sst = (UW+1)'((SW'(cfga_r.off[l]) + cfga_r.dur[l]) * cfga_r.it);
      if (sst > {1'b0, cfga_r.u}) sst = sst - {1'b0, cfga_r.u};
      if (sst == {1'b0, cfga_r.u}) sst = '0;
      cfgb_nxt.sstart[l] = sst[UW-1:0];
      cfgb_nxt.slen[l]   = cfga_r.u - cfgb_nxt.clen[l];
    end
  end

  always_ff @(posedge clk) begin
    cfga_r <= cfga_nxt;
    cfgb_r <= cfgb_nxt;
  end

  // pipe moves whenever the output register is free or being taken
  assign en       = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // count modulo cycle length, four shifted-divisor steps per stage
  always_comb begin
    for (int stg = 0; stg < MOD_STAGES; stg++) begin
      mr = mod_rem_r[stg];
      for (int i = 0; i < MOD_PER_STAGE; i++) begin
        mt = (CW+UW)'(cfga_r.u) << (MOD_STEPS - 1 - (stg * MOD_PER_STAGE + i));
        if ({{UW{1'b0}}, mr} >= mt) mr = mr - mt[CW-1:0];
      end
      mod_rem_nxt[stg+1] = mr;
    end
  end

  // prep: segment index, window progress and lane setup
  always_comb begin
    p  = mod_rem_r[MOD_STAGES][UW-1:0];
    sr = {1'b0, p};
    seg = '0;
    for (int j = 3; j >= 0; j--) begin
      st = (UW+1)'(cfga_r.it) << j;
      if (sr >= st) begin
        sr = sr - st;
        seg[j] = 1'b1;
      end
    end
    ln_len[0]   = cfga_r.u;
    ln_start[1] = cfgb_r.cstart[0];
    ln_start[2] = cfgb_r.cstart[1];
    ln_start[3] = cfgb_r.sstart[0];
    ln_start[4] = cfgb_r.sstart[1];
    ln_len[1]   = cfgb_r.clen[0];
    ln_len[2]   = cfgb_r.clen[1];
    ln_len[3]   = cfgb_r.slen[0];
    ln_len[4]   = cfgb_r.slen[1];

    prep_s.seg          = seg;
    prep_s.contact_bits = '0;
    prep_s.lane[0].mode = LANE_DIV;
    prep_s.lane[0].rem  = p;
    prep_s.lane[0].q    = '0;
    for (int n = 1; n < NLANE; n++) begin
      if (p >= ln_start[n]) pg = p - ln_start[n];
      else pg = UW'({1'b0, p} + {1'b0, cfga_r.u} - {1'b0, ln_start[n]});
      prep_s.lane[n].rem = pg;
      prep_s.lane[n].q   = '0;
      if (ln_len[n] == '0 || pg > ln_len[n]) prep_s.lane[n].mode = LANE_ZERO;
      else if (pg == ln_len[n])              prep_s.lane[n].mode = LANE_FULL;
      else                                   prep_s.lane[n].mode = LANE_DIV;
    end
  end

  // contact table over the horizon from the segment index
  always_comb begin
    tbits = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      tstep = 6'(k) + 6'(stg_r[0].seg);
      if (tstep >= 6'(cfga_r.s)) tstep = tstep - 6'(cfga_r.s);
      for (int l = 0; l < 2; l++) begin
        if (tstep >= 6'(cfga_r.off[l])) tprog = tstep - 6'(cfga_r.off[l]);
        else tprog = tstep + 6'(cfga_r.s) - 6'(cfga_r.off[l]);
        if (6'(k) < 6'(cfga_r.s) && tprog < 6'(cfga_r.dur[l]) && (2 * k + l) < TW)
          tbits[2*k+l] = 1'b1;
      end
    end
  end

  function automatic lane_t div_steps(lane_t ln, logic [UW-1:0] d);
    logic [UW:0] r2;
    lane_t       o;
    o = ln;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, d}) begin
        o.rem = UW'(r2 - {1'b0, d});
        o.q   = {o.q[QW-2:0], 1'b1};
      end else begin
        o.rem = r2[UW-1:0];
        o.q   = {o.q[QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [SUBW-1:0] sub_fmt(lane_t ln);
    case (ln.mode)
      LANE_DIV:  return {1'b0, ln.q};
      LANE_FULL: return SUBW'(1) << QW;
      default:   return '0;
    endcase
  endfunction

  // fraction dividers, four quotient bits per stage
  always_comb begin
    stg_nxt[0] = prep_s;
    for (int i = 1; i < DIV_STAGES; i++) begin
      stg_nxt[i].seg          = stg_r[i-1].seg;
      stg_nxt[i].contact_bits = (i == 1) ? tbits : stg_r[i-1].contact_bits;
      for (int n = 0; n < NLANE; n++)
        stg_nxt[i].lane[n] = div_steps(stg_r[i-1].lane[n], ln_len[n]);
    end
    last.seg          = stg_r[DIV_STAGES-1].seg;
    last.contact_bits = stg_r[DIV_STAGES-1].contact_bits;
    for (int n = 0; n < NLANE; n++)
      last.lane[n] = div_steps(stg_r[DIV_STAGES-1].lane[n], ln_len[n]);
    out_nxt.segment_index     = last.seg;
    out_nxt.cycle_phase       = last.lane[0].q;
    out_nxt.contact_sub_left  = sub_fmt(last.lane[1]);
    out_nxt.contact_sub_right = sub_fmt(last.lane[2]);
    out_nxt.swing_sub_left    = sub_fmt(last.lane[3]);
    out_nxt.swing_sub_right   = sub_fmt(last.lane[4]);
    out_nxt.contact_table     = last.contact_bits;
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      mod_rem_r[0] <= in_if.current_iteration;
      for (int s = 1; s <= MOD_STAGES; s++) mod_rem_r[s] <= mod_rem_nxt[s];
      for (int s = 0; s < DIV_STAGES; s++) stg_r[s] <= stg_nxt[s];
      out_r <= out_nxt;
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NSTG-2:0], in_if.valid};
      out_valid_r <= v_r[NSTG-1];
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.segment_index     = out_r.segment_index;
  assign out_if.cycle_phase       = out_r.cycle_phase;
  assign out_if.contact_sub_left  = out_r.contact_sub_left;
  assign out_if.contact_sub_right = out_r.contact_sub_right;
  assign out_if.swing_sub_left    = out_r.swing_sub_left;
  assign out_if.swing_sub_right   = out_r.swing_sub_right;
  assign out_if.contact_table     = out_r.contact_table;

endmodule

### hw/rtl/bgcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgcs_checker
// Port-level checks on the scheduler result channel.
// ----------------------------------------------------------------------------
module bgcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] contact_sub_left,
  input logic [16:0] contact_sub_right,
  input logic [16:0] swing_sub_left,
  input logic [16:0] swing_sub_right,
  input logic [31:0] contact_table
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(contact_table)
      && $stable(contact_sub_left) && $stable(swing_sub_right))
    else $error("stalled result changed");

  // stance and swing of one leg never both in progress
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(contact_sub_left != 17'd0 && swing_sub_left != 17'd0)
      && !(contact_sub_right != 17'd0 && swing_sub_right != 17'd0))
    else $error("stance and swing overlap");

  // subphases stay within one full window
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> contact_sub_left <= 17'h10000 && contact_sub_right <= 17'h10000
      && swing_sub_left <= 17'h10000 && swing_sub_right <= 17'h10000)
    else $error("subphase out of range");

  // reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind biped_gait_contact_scheduler bgcs_checker u_bgcs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .contact_sub_left  (out_if.contact_sub_left),
  .contact_sub_right (out_if.contact_sub_right),
  .swing_sub_left    (out_if.swing_sub_left),
  .swing_sub_right   (out_if.swing_sub_right),
  .contact_table     (out_if.contact_table)
);

### test/biped_gait_contact_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biped_gait_contact_scheduler_test
// Drives iteration counts through the scheduler under several register
// settings and random flow control, predicts segment, phase, subphases and
// contact table for every transfer, and compares each result in order.
// ----------------------------------------------------------------------------
module biped_gait_contact_scheduler_test;
  import bgcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 80;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bgcs_in_if  count_ch ();
  bgcs_out_if sched_ch ();

  biped_gait_contact_scheduler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (count_ch),
    .out_if  (sched_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadows
  logic [4:0] sh_segments;
  logic [9:0] sh_iters;
  logic [3:0] sh_off_l;
  logic [3:0] sh_off_r;
  logic [4:0] sh_dur_l;
  logic [4:0] sh_dur_r;

  out_t schedule_q[$];
  int   error_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   idle_cycles;
  logic hold_kick;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Q1.16 progress through a window, zero outside it or for an empty window
  function automatic logic [16:0] window_frac(longint unsigned p, longint unsigned start,
                                              longint unsigned len, longint unsigned u);
    longint unsigned prog;
    prog = (p >= start) ? (p - start) : (p + u - start);
    if (len == 0 || prog > len) return '0;
    return 17'((prog << 16) / len);
  endfunction

  // expected schedule for one iteration count under the current registers
  function automatic out_t gait_schedule(logic [31:0] count);
    out_t            r;
    longint unsigned s, it, u, p, seg, cstart, clen, sstart, step, prog;
    longint unsigned off[2];
    longint unsigned dur[2];
    logic [16:0]     csub[2];
    logic [16:0]     ssub[2];
    logic [31:0]     tbl;
    s  = (sh_segments == 0) ? 1 : (sh_segments > MAX_SEGMENTS) ? MAX_SEGMENTS : sh_segments;
    it = (sh_iters == 0) ? 1 : sh_iters;
    off[0] = sh_off_l % s;
    off[1] = sh_off_r % s;
    dur[0] = (sh_dur_l > s) ? s : sh_dur_l;
    dur[1] = (sh_dur_r > s) ? s : sh_dur_r;
    u   = it * s;
    p   = count % u;
    seg = p / it;
    r.segment_index = 4'(seg);
    r.cycle_phase   = 16'((p << 16) / u);
    for (int leg = 0; leg < 2; leg++) begin
      cstart = off[leg] * it;
      clen   = dur[leg] * it;
      sstart = (off[leg] + dur[leg]) * it;
      if (sstart >= u) sstart -= u;
      csub[leg] = window_frac(p, cstart, clen, u);
      ssub[leg] = window_frac(p, sstart, u - clen, u);
    end
    tbl = '0;
    for (int k = 0; k < s; k++) begin
      step = (k + seg) % s;
      for (int leg = 0; leg < 2; leg++) begin
        prog = (step >= off[leg]) ? (step - off[leg]) : (step + s - off[leg]);
        if (prog < dur[leg] && 2 * k + leg < 32) tbl[2 * k + leg] = 1'b1;
      end
    end
    r.contact_sub_left  = csub[0];
    r.contact_sub_right = csub[1];
    r.swing_sub_left    = ssub[0];
    r.swing_sub_right   = ssub[1];
    r.contact_table     = tbl;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && sched_ch.valid && sched_ch.ready) begin
      if (schedule_q.size() == 0) begin
        report_mismatch("unexpected result", sched_ch.contact_table, 0);
      end else begin
        want = schedule_q.pop_front();
        if (sched_ch.segment_index !== want.segment_index)
          report_mismatch("segment_index", sched_ch.segment_index, want.segment_index);
        if (sched_ch.cycle_phase !== want.cycle_phase)
          report_mismatch("cycle_phase", sched_ch.cycle_phase, want.cycle_phase);
        if (sched_ch.contact_sub_left !== want.contact_sub_left)
          report_mismatch("contact_sub_left", sched_ch.contact_sub_left,
                          want.contact_sub_left);
        if (sched_ch.contact_sub_right !== want.contact_sub_right)
          report_mismatch("contact_sub_right", sched_ch.contact_sub_right,
                          want.contact_sub_right);
        if (sched_ch.swing_sub_left !== want.swing_sub_left)
          report_mismatch("swing_sub_left", sched_ch.swing_sub_left, want.swing_sub_left);
        if (sched_ch.swing_sub_right !== want.swing_sub_right)
          report_mismatch("swing_sub_right", sched_ch.swing_sub_right,
                          want.swing_sub_right);
        if (sched_ch.contact_table !== want.contact_table)
          report_mismatch("contact_table", sched_ch.contact_table, want.contact_table);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    int   hold_left;
    logic kick_seen;
    if (!rst_n) begin
      hold_left = 0;
      kick_seen = hold_kick;
      sched_ch.ready <= 1'b0;
    end else begin
      if (hold_kick != kick_seen) begin
        kick_seen = hold_kick;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        sched_ch.ready <= 1'b0;
      end else begin
        sched_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((count_ch.valid && count_ch.ready) || (sched_ch.valid && sched_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one count and hold it until the transfer; valid stays up afterwards
  task automatic send_count(logic [31:0] count);
    if ($urandom_range(99) < send_idle_pct) begin
      count_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    count_ch.valid             <= 1'b1;
    count_ch.current_iteration <= count;
    do @(posedge clk); while (!count_ch.ready);
    schedule_q.push_back(gait_schedule(count));
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain_results();
    count_ch.valid <= 1'b0;
    @(posedge clk);
    while (schedule_q.size() > 0) @(posedge clk);
  endtask

  // APB write: setup then access; updates the shadow
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_HORIZON_SEGMENTS: sh_segments = value[4:0];
      REG_ITERATIONS:       sh_iters    = value[9:0];
      REG_OFFSET_LEFT:      sh_off_l    = value[3:0];
      REG_OFFSET_RIGHT:     sh_off_r    = value[3:0];
      REG_DURATION_LEFT:    sh_dur_l    = value[4:0];
      REG_DURATION_RIGHT:   sh_dur_r    = value[4:0];
      default: ;
    endcase
  endtask

  // write all six registers once the pipe is empty
  task automatic set_gait(int segs, int iters, int off_l, int off_r, int dur_l, int dur_r);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_HORIZON_SEGMENTS, segs);
    write_reg(REG_ITERATIONS, iters);
    write_reg(REG_OFFSET_LEFT, off_l);
    write_reg(REG_OFFSET_RIGHT, off_r);
    write_reg(REG_DURATION_LEFT, dur_l);
    write_reg(REG_DURATION_RIGHT, dur_r);
  endtask

  // count near a segment boundary or the top of the count range, or random
  function automatic logic [31:0] pick_count();
    int unsigned s, it, u;
    s  = (sh_segments == 0) ? 1 : (sh_segments > MAX_SEGMENTS) ? MAX_SEGMENTS : sh_segments;
    it = (sh_iters == 0) ? 1 : sh_iters;
    u  = s * it;
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(3 * u);
      2: return $urandom_range(1000000) * u + $urandom_range(s) * it
                - $urandom_range(1) + $urandom_range(1);
      default: return 32'hFFFF_FFFF - $urandom_range(2 * u);
    endcase
  endfunction

  // reset values, then window and wrap corners
  task automatic test_reset_setting();
    logic [31:0] counts[12];
    counts = '{0, 1, 39, 40, 199, 200, 201, 399, 400, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h5555_5555};
    foreach (counts[i]) send_count(counts[i]);
  endtask

  // register extremes and the clamped cases
  task automatic test_register_extremes();
    set_gait(1, 1, 0, 0, 0, 1);
    send_count(0);
    send_count(32'hFFFF_FFFF);
    set_gait(16, 1023, 15, 0, 16, 0);
    send_count(16367);
    send_count(16368);
    send_count(32'hAAAA_AAAA);
    set_gait(0, 0, 15, 15, 31, 31);
    send_count(7);
    set_gait(31, 5, 3, 9, 16, 8);
    send_count(79);
    send_count(80);
    set_gait(4, 3, 13, 6, 0, 4);
    send_count(2);
    send_count(11);
  endtask

  // random settings and counts under one idling pattern
  task automatic test_random_phase(int s_pct, int r_pct, int n_items, logic with_pressure);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int chunk = 0; chunk < 8; chunk++) begin
      set_gait($urandom_range(31), $urandom_range(1023), $urandom_range(15),
               $urandom_range(15), $urandom_range(31), $urandom_range(31));
      if ($urandom_range(3) == 0) write_reg(REG_ITERATIONS, $urandom_range(12, 1));
      for (int i = 0; i < n_items / 8; i++) begin
        if (with_pressure && chunk == 2 && i == 5) hold_kick = ~hold_kick;
        if (with_pressure && chunk == 5 && i == 40) drain_results();
        send_count(pick_count());
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    count_ch.valid = 1'b0;
    count_ch.current_iteration = '0;
    sched_ch.ready = 1'b0;
    hold_kick      = 1'b0;
    idle_cycles    = 0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sh_segments = 10;
    sh_iters    = 40;
    sh_off_l    = 0;
    sh_off_r    = 5;
    sh_dur_l    = 5;
    sh_dur_r    = 5;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_register_extremes();
    test_random_phase(34, 55, 640, 1'b0);
    test_random_phase(55, 34, 640, 1'b0);
    test_random_phase(0, 0, 640, 1'b1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
